// ===== hw/rtl/lcgai_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgai_pkg
// Shared types and constants of the LCG advance and init engine.
// ----------------------------------------------------------------------------
package lcgai_pkg;

    // Field widths of the request and response channels
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned XLIM_W  = 32;
    localparam int unsigned STATE_W = 64;
    localparam int unsigned RAND_W  = 32;
    localparam int unsigned FRAME_W = 32;
    localparam int unsigned HALF_W  = 32;

    // Generator constants, multiplier split in halves for the 32x32 unit
    localparam logic [HALF_W-1:0]  LCG_MUL_HI = 32'h5D58_8B65;
    localparam logic [HALF_W-1:0]  LCG_MUL_LO = 32'h6C07_8965;
    localparam logic [STATE_W-1:0] LCG_ADD    = 64'h0000_0000_0026_9EC3;

    // Configuration register indexes
    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // Init sequence constants
    localparam logic [XLIM_W-1:0] SCALE_TAB   = 32'd101;
    localparam logic [XLIM_W-1:0] SCALE_TRIP  = 32'd15;
    localparam logic [6:0]        TRIP_MAX    = 7'd100;
    localparam logic [6:0]        PLAIN_STEPS = 7'd3;
    localparam logic [2:0]        ROUNDS_M0   = 3'd5;
    localparam logic [2:0]        ROUNDS_M1A  = 3'd1;
    localparam logic [2:0]        ROUNDS_M1B  = 3'd4;
    localparam logic [2:0]        LAST_ROW    = 3'd4;
    localparam logic [1:0]        LAST_COL    = 2'd3;
    localparam logic [6:0]        THRESH_END  = 7'd100;

    localparam logic [6:0] THRESH_TAB [0:4][0:3] = '{
        '{7'd50, 7'd100, 7'd100, 7'd100},
        '{7'd50, 7'd50,  7'd100, 7'd100},
        '{7'd30, 7'd50,  7'd100, 7'd100},
        '{7'd25, 7'd30,  7'd50,  7'd100},
        '{7'd20, 7'd25,  7'd33,  7'd50}
    };

    typedef enum logic [1:0] {
        KIND_ADV     = 2'd0,
        KIND_PEEK    = 2'd1,
        KIND_INIT    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_STEP,
        ST_DRAW,
        ST_SCALE,
        ST_EVAL,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        IPH_TAB_A,
        IPH_PLAIN,
        IPH_TAB_B,
        IPH_TRIP,
        IPH_DONE
    } t_iph;

    typedef enum logic {
        MOP_STEP,
        MOP_SCALE
    } t_mop;

    typedef struct packed {
        logic start;
        t_mop op;
    } t_mu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mu_sts;

endpackage

// ===== hw/rtl/lcgai_req_if.sv =====
// ----------------------------------------------------------------------------
// lcgai_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface lcgai_req_if;
    import lcgai_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [STEP_W-1:0] step_count;
    logic [XLIM_W-1:0] range_limit;

    modport source (output valid, output req_type, output step_count,
                    output range_limit, input ready);
    modport sink   (input valid, input req_type, input step_count,
                    input range_limit, output ready);
endinterface

// ===== hw/rtl/lcgai_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lcgai_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface lcgai_rsp_if;
    import lcgai_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] state_value;
    logic [RAND_W-1:0]  rand_value;
    logic [FRAME_W-1:0] frame_out;

    modport source (output valid, output state_value, output rand_value,
                    output frame_out, input ready);
    modport sink   (input valid, input state_value, input rand_value,
                    input frame_out, output ready);
endinterface

// ===== hw/rtl/lcgai_mul_unit.sv =====
// ----------------------------------------------------------------------------
// lcgai_mul_unit
// Shared 32x32 multiplier that runs one generator step (three partial
// products) or one scaled draw (one product) per command.
// ----------------------------------------------------------------------------
module lcgai_mul_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcgai_pkg::t_mu_cmd              i_cmd,
    input  logic [lcgai_pkg::STATE_W-1:0]   i_state,
    input  logic [lcgai_pkg::XLIM_W-1:0]    i_x,
    output lcgai_pkg::t_mu_sts              o_sts,
    output logic [lcgai_pkg::STATE_W-1:0]   o_state,
    output logic [lcgai_pkg::RAND_W-1:0]    o_rand
);
    import lcgai_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [1:0]         r_ph,   n_ph;
    t_mop               r_op,   n_op;
    logic [STATE_W-1:0] r_s,    n_s;
    logic [XLIM_W-1:0]  r_x,    n_x;
    logic [STATE_W-1:0] r_prod;
    logic [STATE_W-1:0] r_acc,  n_acc;
    logic [RAND_W-1:0]  r_rand, n_rand;
    logic [HALF_W-1:0]  mul_a,  mul_b;

    // Operand select per phase
    always_comb begin
        case (r_ph)
            2'd0: begin
                if (r_op == MOP_SCALE) begin
                    mul_a = r_s[STATE_W-1:HALF_W];
                    mul_b = r_x;
                end else begin
                    mul_a = r_s[HALF_W-1:0];
                    mul_b = LCG_MUL_LO;
                end
            end
            2'd1: begin
                mul_a = r_s[HALF_W-1:0];
                mul_b = LCG_MUL_HI;
            end
            2'd2: begin
                mul_a = r_s[STATE_W-1:HALF_W];
                mul_b = LCG_MUL_LO;
            end
            default: begin
                mul_a = r_s[HALF_W-1:0];
                mul_b = LCG_MUL_LO;
            end
        endcase
    end

    // Accumulate the registered product of the previous phase
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_ph   = r_ph;
        n_op   = r_op;
        n_s    = r_s;
        n_x    = r_x;
        n_acc  = r_acc;
        n_rand = r_rand;
        if (r_busy) begin
            n_ph = r_ph + 2'd1;
            case (r_ph)
                2'd1: begin
                    if (r_op == MOP_SCALE) begin
                        n_rand = r_prod[STATE_W-1:HALF_W];
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_acc = r_prod + LCG_ADD;
                    end
                end
                2'd2: begin
                    n_acc = {r_acc[STATE_W-1:HALF_W] + r_prod[HALF_W-1:0],
                             r_acc[HALF_W-1:0]};
                end
                2'd3: begin
                    n_acc  = {r_acc[STATE_W-1:HALF_W] + r_prod[HALF_W-1:0],
                              r_acc[HALF_W-1:0]};
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_ph   = 2'd0;
            n_op   = i_cmd.op;
            n_s    = i_state;
            n_x    = i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ph   <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_s    <= n_s;
        r_x    <= n_x;
        r_prod <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
        r_acc  <= n_acc;
        r_rand <= n_rand;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_state    = r_acc;
    assign o_rand     = r_rand;

endmodule

// ===== hw/rtl/lcg64_advance_init_engine.sv =====
// ----------------------------------------------------------------------------
// lcg64_advance_init_engine
// 64-bit LCG with frame counter: advance, peek, start-up init and restart.
// ----------------------------------------------------------------------------
// The engine keeps a 64-bit generator state (s = s * 0x5D588B656C078965 +
// 0x269EC3) and a wrapping 32-bit frame count, and answers each request with
// exactly one response. It handles one request at a time: ready is high only
// while idle, and the response is held until taken. All arithmetic goes
// through one shared 32x32 multiplier; a generator step uses it for three
// partial products, a scaled draw uses it for one. An advance or peek of n
// steps runs n generator steps and then one scaled draw before its response;
// a restart shows its response in the cycle after accept. An init request
// walks the threshold table with a step plus a draw per entry, and mode 1
// also runs plain steps, a second table walk and the distinct-triple search.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
module lcg64_advance_init_engine #(
    parameter int unsigned STEP_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lcgai_req_if.sink                     i_req,
    lcgai_rsp_if.source                   o_rsp,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [lcgai_pkg::STATE_W-1:0] i_cfg_wdata
);
    import lcgai_pkg::*;

    // Step counter width: step_count bits that the count may use
    localparam int unsigned NW = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;

    t_state             r_state, n_state;
    logic [STATE_W-1:0] r_lcg,   n_lcg;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [STATE_W-1:0] r_seed;
    logic               r_mode;
    t_kind              r_kind,  n_kind;
    logic [NW-1:0]      r_n,     n_n;
    logic [XLIM_W-1:0]  r_x,     n_x;
    logic [STATE_W-1:0] r_work,  n_work;
    logic [RAND_W-1:0]  r_rand,  n_rand;
    t_iph               r_iph,   n_iph;
    logic [2:0]         r_round, n_round;
    logic [2:0]         r_row,   n_row;
    logic [1:0]         r_col,   n_col;
    logic [6:0]         r_cnt,   n_cnt;
    logic [1:0]         r_tri,   n_tri;
    logic [3:0]         r_a,     n_a;
    logic [3:0]         r_b,     n_b;

    t_mu_cmd            mu_cmd;
    t_mu_sts            mu_sts;
    logic [XLIM_W-1:0]  mu_x;
    logic [STATE_W-1:0] mu_state;
    logic [RAND_W-1:0]  mu_rand;

    logic               req_acc;
    logic               end_row;
    logic [6:0]         thr;
    logic [2:0]         round_lim;

    lcgai_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mu_cmd),
        .i_state (r_work),
        .i_x     (mu_x),
        .o_sts   (mu_sts),
        .o_state (mu_state),
        .o_rand  (mu_rand)
    );

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    assign o_rsp.valid       = (r_state == ST_OUT);
    assign o_rsp.state_value = r_work;
    assign o_rsp.rand_value  = r_rand;
    assign o_rsp.frame_out   = r_frame;

    assign thr       = THRESH_TAB[r_row][r_col];
    assign round_lim = (r_iph == IPH_TAB_B) ? ROUNDS_M1B :
                       (r_mode ? ROUNDS_M1A : ROUNDS_M0);

    // Sequencer: next state, unit commands and datapath updates
    always_comb begin
        n_state = r_state;
        n_lcg   = r_lcg;
        n_frame = r_frame;
        n_kind  = r_kind;
        n_n     = r_n;
        n_x     = r_x;
        n_work  = r_work;
        n_rand  = r_rand;
        n_iph   = r_iph;
        n_round = r_round;
        n_row   = r_row;
        n_col   = r_col;
        n_cnt   = r_cnt;
        n_tri   = r_tri;
        n_a     = r_a;
        n_b     = r_b;
        end_row = 1'b0;
        mu_cmd.start = 1'b0;
        mu_cmd.op    = MOP_STEP;
        mu_x         = r_x;

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_kind  = t_kind'(i_req.req_type);
                    n_n     = i_req.step_count[NW-1:0];
                    n_x     = i_req.range_limit;
                    n_work  = r_lcg;
                    n_rand  = '0;
                    n_iph   = IPH_TAB_A;
                    n_round = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_cnt   = '0;
                    n_tri   = '0;
                    n_state = ST_RUN;
                    // Restart: load the seed and clear the frame at once
                    if (t_kind'(i_req.req_type) == KIND_RESTART) begin
                        n_lcg   = r_seed;
                        n_work  = r_seed;
                        n_frame = '0;
                        n_state = ST_OUT;
                    end
                end
            end

            ST_RUN: begin
                case (r_kind)
                    KIND_ADV, KIND_PEEK: begin
                        mu_cmd.start = 1'b1;
                        if (r_n != '0) begin
                            mu_cmd.op = MOP_STEP;
                            n_state   = ST_STEP;
                        end else begin
                            mu_cmd.op = MOP_SCALE;
                            n_state   = ST_SCALE;
                        end
                    end
                    KIND_INIT: begin
                        case (r_iph)
                            IPH_TAB_A, IPH_TAB_B: begin
                                if (r_round == round_lim) begin
                                    // Table rounds finished: move to next phase
                                    n_round = '0;
                                    n_row   = '0;
                                    n_col   = '0;
                                    n_cnt   = '0;
                                    n_tri   = '0;
                                    if (r_iph == IPH_TAB_B) begin
                                        n_iph = IPH_TRIP;
                                    end else if (r_mode) begin
                                        n_iph = IPH_PLAIN;
                                    end else begin
                                        n_iph = IPH_DONE;
                                    end
                                end else if (thr == THRESH_END) begin
                                    end_row = 1'b1;
                                end else begin
                                    mu_cmd.start = 1'b1;
                                    n_state      = ST_STEP;
                                end
                            end
                            IPH_PLAIN: begin
                                if (r_cnt == PLAIN_STEPS) begin
                                    n_iph   = IPH_TAB_B;
                                    n_round = '0;
                                    n_row   = '0;
                                    n_col   = '0;
                                end else begin
                                    mu_cmd.start = 1'b1;
                                    n_state      = ST_STEP;
                                end
                            end
                            IPH_TRIP: begin
                                if (r_cnt == TRIP_MAX) begin
                                    n_iph = IPH_DONE;
                                end else begin
                                    mu_cmd.start = 1'b1;
                                    n_state      = ST_STEP;
                                end
                            end
                            default: begin
                                n_rand  = '0;
                                n_state = ST_OUT;
                            end
                        endcase
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end

            ST_STEP: begin
                if (mu_sts.done) begin
                    n_work = mu_state;
                    // Peek works on a private copy; everything else commits
                    if (r_kind != KIND_PEEK) begin
                        n_lcg   = mu_state;
                        n_frame = r_frame + {{(FRAME_W-1){1'b0}}, 1'b1};
                    end
                    if (r_kind == KIND_INIT) begin
                        n_state = (r_iph == IPH_PLAIN) ? ST_EVAL : ST_DRAW;
                    end else begin
                        n_n     = r_n - {{(NW-1){1'b0}}, 1'b1};
                        n_state = ST_RUN;
                    end
                end
            end

            ST_DRAW: begin
                mu_cmd.start = 1'b1;
                mu_cmd.op    = MOP_SCALE;
                mu_x         = (r_iph == IPH_TRIP) ? SCALE_TRIP : SCALE_TAB;
                n_state      = ST_SCALE;
            end

            ST_SCALE: begin
                if (mu_sts.done) begin
                    n_rand  = mu_rand;
                    n_state = (r_kind == KIND_INIT) ? ST_EVAL : ST_OUT;
                end
            end

            ST_EVAL: begin
                n_state = ST_RUN;
                case (r_iph)
                    IPH_TAB_A, IPH_TAB_B: begin
                        if ((r_rand <= {25'd0, thr}) || (r_col == LAST_COL)) begin
                            end_row = 1'b1;
                        end else begin
                            n_col = r_col + 2'd1;
                        end
                    end
                    IPH_PLAIN: begin
                        n_cnt = r_cnt + 7'd1;
                    end
                    IPH_TRIP: begin
                        case (r_tri)
                            2'd0: begin
                                n_a   = r_rand[3:0];
                                n_tri = 2'd1;
                            end
                            2'd1: begin
                                n_b   = r_rand[3:0];
                                n_tri = 2'd2;
                            end
                            default: begin
                                n_tri = 2'd0;
                                // Stop at the first triple of distinct values
                                if ((r_a != r_b) && (r_a != r_rand[3:0]) &&
                                    (r_b != r_rand[3:0])) begin
                                    n_iph = IPH_DONE;
                                end else begin
                                    n_cnt = r_cnt + 7'd1;
                                end
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end

            ST_OUT: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Close a table row: advance row, wrap into the next round
        if (end_row) begin
            n_col = '0;
            if (r_row == LAST_ROW) begin
                n_row   = '0;
                n_round = r_round + 3'd1;
            end else begin
                n_row = r_row + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lcg   <= '0;
            r_frame <= '0;
            r_seed  <= '0;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lcg   <= n_lcg;
            r_frame <= n_frame;
            if (i_cfg_we && (i_cfg_idx == CFG_SEED)) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_MODE)) begin
                r_mode <= i_cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_n     <= n_n;
        r_x     <= n_x;
        r_work  <= n_work;
        r_rand  <= n_rand;
        r_iph   <= n_iph;
        r_round <= n_round;
        r_row   <= n_row;
        r_col   <= n_col;
        r_cnt   <= n_cnt;
        r_tri   <= n_tri;
        r_a     <= n_a;
        r_b     <= n_b;
    end

    // Never issue a command to the multiplier while it is still working
    a_mu_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mu_cmd.start |-> !mu_sts.busy)
        else $error("multiplier command issued while busy");

    // A peek step must leave the committed state and frame untouched
    a_peek_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && r_kind == KIND_PEEK) |=>
            ($stable(r_lcg) && $stable(r_frame)))
        else $error("peek changed generator state");

    // Restart responds in the next cycle with a cleared frame
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.req_type == KIND_RESTART) |=>
            (o_rsp.valid && r_frame == '0 && r_lcg == r_seed))
        else $error("restart did not load seed");

    // Never take a request while a response is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while response pending");

endmodule
